FILE: hdl/mrfc_pkg.sv
// ----------------------------------------------------------------------------
// mrfc_pkg
// Shared types and constants for the motor reply frame checker.
// ----------------------------------------------------------------------------
package mrfc_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned LEN_W        = 4;
  localparam int unsigned PAYLOAD_W    = 64;
  localparam int unsigned MAX_DATA_DEF = 8;

  localparam logic [BYTE_W-1:0] START_BYTE   = 8'h3E;
  localparam logic [BYTE_W-1:0] MOTOR_ID_RST = 8'd1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FORMAT = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CSUM   = 2'd2;

  typedef struct packed {
    logic [STATUS_W-1:0]  status;
    logic [BYTE_W-1:0]    command;
    logic [LEN_W-1:0]     data_len;
    logic [PAYLOAD_W-1:0] payload;
  } result_t;

endpackage

FILE: hdl/mrfc_parser.sv
// ----------------------------------------------------------------------------
// mrfc_parser
// Frame state machine: takes one byte per accepted item, checks id, length,
// header and data sums, and produces at most one result per byte.
// ----------------------------------------------------------------------------
module mrfc_parser
  import mrfc_pkg::*;
#(
  parameter int unsigned MaxData = MAX_DATA_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [BYTE_W-1:0] cfg_wdata_i,
  input  logic              byte_valid_i,
  input  logic [BYTE_W-1:0] rx_byte_i,
  output logic              res_valid_o,
  output result_t           res_o
);

  localparam int unsigned PlW = MaxData * BYTE_W;

  localparam logic [2:0] PH_HUNT = 3'd0;
  localparam logic [2:0] PH_CMD  = 3'd1;
  localparam logic [2:0] PH_ID   = 3'd2;
  localparam logic [2:0] PH_LEN  = 3'd3;
  localparam logic [2:0] PH_HSUM = 3'd4;
  localparam logic [2:0] PH_DATA = 3'd5;
  localparam logic [2:0] PH_DSUM = 3'd6;

  logic [2:0]        phase_q, phase_d;
  logic [BYTE_W-1:0] motor_id_q;
  logic [BYTE_W-1:0] cmd_q, cmd_d;
  logic [LEN_W-1:0]  len_q, len_d;
  logic [BYTE_W-1:0] hsum_q, hsum_d;
  logic [BYTE_W-1:0] dsum_q, dsum_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [PlW-1:0]    payload_q, payload_d;
  logic [BYTE_W-1:0] b;

  assign b = rx_byte_i;

  always_comb begin
    phase_d     = phase_q;
    cmd_d       = cmd_q;
    len_d       = len_q;
    hsum_d      = hsum_q;
    dsum_d      = dsum_q;
    cnt_d       = cnt_q;
    payload_d   = payload_q;
    res_valid_o = 1'b0;
    res_o       = '{status: ST_FORMAT, command: cmd_q, data_len: '0, payload: '0};
    unique case (phase_q)
      PH_CMD: begin
        cmd_d   = b;
        res_o.command = b;
        hsum_d  = hsum_q + b;
        phase_d = PH_ID;
      end
      PH_ID: begin
        if (b != motor_id_q) begin
          res_valid_o = 1'b1;
          phase_d     = PH_HUNT;
        end else begin
          hsum_d  = hsum_q + b;
          phase_d = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b > BYTE_W'(MaxData)) begin
          res_valid_o = 1'b1;
          phase_d     = PH_HUNT;
        end else begin
          len_d   = b[LEN_W-1:0];
          hsum_d  = hsum_q + b;
          phase_d = PH_HSUM;
        end
      end
      PH_HSUM: begin
        if (b != hsum_q) begin
          res_valid_o = 1'b1;
          phase_d     = PH_HUNT;
        end else if (len_q == '0) begin
          res_valid_o  = 1'b1;
          res_o.status = ST_OK;
          phase_d      = PH_HUNT;
        end else begin
          dsum_d    = '0;
          cnt_d     = '0;
          payload_d = '0;
          phase_d   = PH_DATA;
        end
      end
      PH_DATA: begin
        // count stays below len, which never exceeds MaxData
        for (int unsigned i = 0; i < MaxData; i++) begin
          if (cnt_q == LEN_W'(i)) payload_d[i*BYTE_W +: BYTE_W] = b;
        end
        dsum_d = dsum_q + b;
        cnt_d  = cnt_q + LEN_W'(1);
        if (cnt_d >= len_q) phase_d = PH_DSUM;
      end
      PH_DSUM: begin
        res_valid_o    = 1'b1;
        res_o.status   = (b == dsum_q) ? ST_OK : ST_CSUM;
        res_o.data_len = len_q;
        res_o.payload  = PAYLOAD_W'(payload_q);
        phase_d        = PH_HUNT;
      end
      default: begin
        phase_d = PH_HUNT;
        if (b == START_BYTE) begin
          hsum_d  = START_BYTE;
          phase_d = PH_CMD;
        end
      end
    endcase
    if (!byte_valid_i) res_valid_o = 1'b0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_HUNT;
      motor_id_q <= MOTOR_ID_RST;
    end else begin
      if (byte_valid_i) phase_q <= phase_d;
      if (cfg_we_i) motor_id_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (byte_valid_i) begin
      cmd_q     <= cmd_d;
      len_q     <= len_d;
      hsum_q    <= hsum_d;
      dsum_q    <= dsum_d;
      cnt_q     <= cnt_d;
      payload_q <= payload_d;
    end
  end

  a_res_needs_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> byte_valid_i)
    else $error("result without an accepted byte");

  a_res_back_to_hunt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> phase_q == PH_HUNT)
    else $error("frame checker not hunting after a result");

  a_len_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DATA || phase_q == PH_DSUM) |-> (len_q != '0 &&
      len_q <= LEN_W'(MaxData)))
    else $error("data phase with out-of-range length");

endmodule

FILE: hdl/mrfc_outbuf.sv
// ----------------------------------------------------------------------------
// mrfc_outbuf
// Result register with one skid entry; the input side stalls only while the
// skid entry is occupied.
// ----------------------------------------------------------------------------
module mrfc_outbuf
  import mrfc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    res_valid_i,
  input  result_t res_i,
  output logic    full_o,
  output logic    out_valid_o,
  input  logic    out_stall_i,
  output result_t out_o
);

  logic    ov_q, sv_q;
  result_t out_q, skid_q;
  logic    take;

  assign take        = ov_q && !out_stall_i;
  assign full_o      = sv_q;
  assign out_valid_o = ov_q;
  assign out_o       = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      sv_q <= 1'b0;
    end else if (sv_q) begin
      if (take) sv_q <= 1'b0;
    end else if (res_valid_i) begin
      if (!ov_q || take) ov_q <= 1'b1;
      else sv_q <= 1'b1;
    end else if (take) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sv_q) begin
      if (take) out_q <= skid_q;
    end else if (res_valid_i) begin
      if (!ov_q || take) out_q <= res_i;
      else skid_q <= res_i;
    end
  end

  a_skid_implies_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> ov_q)
    else $error("skid entry held while result register empty");

  a_no_res_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sv_q |-> !res_valid_i)
    else $error("result arrived while buffer full");

  a_drain_keeps_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (sv_q && !out_stall_i) |=> (ov_q && !sv_q))
    else $error("skid entry lost on drain");

endmodule

FILE: hdl/motor_reply_frame_checker_top.sv
// ----------------------------------------------------------------------------
// motor_reply_frame_checker_top
// Byte-serial deframer for motor reply frames with header and data sums.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o  | rx_byte_i
//  out     | out_valid_o / out_stall_i| status_o, command_o, data_len_o,
//          |                          | payload_o
//  cfg     | cfg_we_i                 | cfg_wdata_i (motor id)
//
// One byte per cycle sustained while in_stall_o is low; the result of the byte
// that ends or rejects a frame is registered and leaves from the result register.
// Reset clears the frame phase to hunting and sets the motor id to 1.
// A stalled output fills the result register, then one skid entry; only
// then is the input stalled.
// ----------------------------------------------------------------------------
module motor_reply_frame_checker_top
  import mrfc_pkg::*;
#(
  parameter int unsigned MaxData = MAX_DATA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic [STATUS_W-1:0]  status_o,
  output logic [BYTE_W-1:0]    command_o,
  output logic [LEN_W-1:0]     data_len_o,
  output logic [PAYLOAD_W-1:0] payload_o
);

  logic    full;
  logic    accept;
  logic    res_valid;
  result_t res, out;

  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  mrfc_parser #(
    .MaxData(MaxData)
  ) u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .byte_valid_i(accept),
    .rx_byte_i   (rx_byte_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  mrfc_outbuf u_outbuf (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .res_valid_i(res_valid),
    .res_i      (res),
    .full_o     (full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out)
  );

  assign status_o   = out.status;
  assign command_o  = out.command;
  assign data_len_o = out.data_len;
  assign payload_o  = out.payload;

endmodule

FILE: bench/mrfc_frame_monitor.sv
// ----------------------------------------------------------------------------
// mrfc_frame_monitor
// Watches the byte and reply channels of the motor reply frame checker,
// deframes the accepted bytes itself and compares every reply in order.
// ----------------------------------------------------------------------------
module mrfc_frame_monitor
  import mrfc_pkg::*;
#(
  parameter int unsigned MaxData = MAX_DATA_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [BYTE_W-1:0]    cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_stall_i,
  input  logic [BYTE_W-1:0]    rx_byte_i,
  input  logic                 out_valid_i,
  input  logic                 out_stall_i,
  input  logic [STATUS_W-1:0]  status_i,
  input  logic [BYTE_W-1:0]    command_i,
  input  logic [LEN_W-1:0]     data_len_i,
  input  logic [PAYLOAD_W-1:0] payload_i,
  output int                   mismatches_o,
  output int                   pending_o,
  output int                   replies_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum logic [2:0] {
    PH_HUNT, PH_CMD, PH_ID, PH_LEN, PH_HSUM, PH_DATA, PH_DSUM
  } phase_e;

  phase_e               phase;
  logic [BYTE_W-1:0]    motor_id;
  logic [BYTE_W-1:0]    cmd_q;
  logic [BYTE_W-1:0]    head_sum;
  logic [BYTE_W-1:0]    data_sum;
  logic [LEN_W-1:0]     len_q;
  logic [LEN_W-1:0]     nbytes;
  logic [PAYLOAD_W-1:0] payload_q;
  result_t              expected_replies[$];

  // Advances the frame state by one byte; returns 1 when a reply is due.
  function automatic bit deframe_byte(input logic [BYTE_W-1:0] b, output result_t r);
    bit done;
    done = 1'b0;
    r = '0;
    case (phase)
      PH_CMD: begin
        cmd_q = b;
        head_sum = head_sum + b;
        phase = PH_ID;
      end
      PH_ID: begin
        if (b != motor_id) begin
          r.status = ST_FORMAT;
          done = 1'b1;
        end else begin
          head_sum = head_sum + b;
          phase = PH_LEN;
        end
      end
      PH_LEN: begin
        if (b > MaxData) begin
          r.status = ST_FORMAT;
          done = 1'b1;
        end else begin
          len_q = b[LEN_W-1:0];
          head_sum = head_sum + b;
          phase = PH_HSUM;
        end
      end
      PH_HSUM: begin
        if (b != head_sum) begin
          r.status = ST_FORMAT;
          done = 1'b1;
        end else if (len_q == '0) begin
          r.status = ST_OK;
          done = 1'b1;
        end else begin
          data_sum = '0;
          nbytes = '0;
          payload_q = '0;
          phase = PH_DATA;
        end
      end
      PH_DATA: begin
        payload_q = payload_q | ({{(PAYLOAD_W-BYTE_W){1'b0}}, b} << (8 * nbytes[2:0]));
        data_sum = data_sum + b;
        nbytes = nbytes + 1'b1;
        if (nbytes >= len_q) phase = PH_DSUM;
      end
      PH_DSUM: begin
        r.status = (b == data_sum) ? ST_OK : ST_CSUM;
        r.data_len = len_q;
        r.payload = payload_q;
        done = 1'b1;
      end
      default: begin
        // unused codes fall back to hunting as well
        phase = PH_HUNT;
        if (b == START_BYTE) begin
          head_sum = START_BYTE;
          phase = PH_CMD;
        end
      end
    endcase
    if (done) begin
      r.command = cmd_q;
      phase = PH_HUNT;
    end
    return done;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t want;
    if (!rst_ni) begin
      phase = PH_HUNT;
      motor_id = MOTOR_ID_RST;
      cmd_q = '0;
      head_sum = '0;
      data_sum = '0;
      len_q = '0;
      nbytes = '0;
      payload_q = '0;
      expected_replies.delete();
      mismatches_o = 0;
      replies_o = 0;
      pending_o = 0;
    end else begin
      // reply first: a byte taken at this edge cannot have produced it
      if (out_valid_i && !out_stall_i) begin
        if (expected_replies.size() == 0) begin
          $error("unexpected reply: status %0d command %02h len %0d payload %016h",
                 status_i, command_i, data_len_i, payload_i);
          mismatches_o++;
        end else begin
          want = expected_replies.pop_front();
          replies_o++;
          if (status_i !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, status_i);
            mismatches_o++;
          end
          if (command_i !== want.command) begin
            $error("command: expected %02h, got %02h", want.command, command_i);
            mismatches_o++;
          end
          if (data_len_i !== want.data_len) begin
            $error("data_len: expected %0d, got %0d", want.data_len, data_len_i);
            mismatches_o++;
          end
          if (payload_i !== want.payload) begin
            $error("payload: expected %016h, got %016h", want.payload, payload_i);
            mismatches_o++;
          end
        end
      end
      if (cfg_we_i) motor_id = cfg_wdata_i;
      if (in_valid_i && !in_stall_i) begin
        if (deframe_byte(rx_byte_i, want)) expected_replies.push_back(want);
      end
      pending_o = expected_replies.size();
    end
  end

endmodule

FILE: bench/tb_motor_reply_frame_checker_top.sv
// ----------------------------------------------------------------------------
// tb_motor_reply_frame_checker_top
// Drives reply frames (clean, corrupted and noise) into the frame checker
// under several motor ids with bursty input and stalled output; the monitor
// beside the block predicts and compares every reply.
// ----------------------------------------------------------------------------
module tb_motor_reply_frame_checker_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mrfc_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 80;

  typedef enum int {FAULT_NONE, FAULT_HEAD, FAULT_DATA} frame_fault_e;
  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PERIODIC} rx_mode_e;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [BYTE_W-1:0]    cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_stall_o;
  logic [BYTE_W-1:0]    rx_byte_i;
  logic                 out_valid_o;
  logic                 out_stall_i;
  logic [STATUS_W-1:0]  status_o;
  logic [BYTE_W-1:0]    command_o;
  logic [LEN_W-1:0]     data_len_o;
  logic [PAYLOAD_W-1:0] payload_o;

  int                   mismatches;
  int                   pending;
  int                   replies;

  logic [BYTE_W-1:0]    cur_id;
  logic [BYTE_W-1:0]    id_plan [6] = '{MOTOR_ID_RST, 8'h00, 8'hFF, START_BYTE, 8'h00, 8'h01};
  rx_mode_e             rx_mode;
  bit                   hold_req;
  int                   max_gap;
  int                   burst_left;
  int                   frame_bytes;

  motor_reply_frame_checker_top u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .rx_byte_i  (rx_byte_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .status_o   (status_o),
    .command_o  (command_o),
    .data_len_o (data_len_o),
    .payload_o  (payload_o)
  );

  mrfc_frame_monitor u_monitor (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_i  (in_stall_o),
    .rx_byte_i   (rx_byte_i),
    .out_valid_i (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status_o),
    .command_i   (command_o),
    .data_len_i  (data_len_o),
    .payload_i   (payload_o),
    .mismatches_o(mismatches),
    .pending_o   (pending),
    .replies_o   (replies)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Receiver stall pattern, with a long hold-off on request
  initial begin
    int cyc;
    cyc = 0;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      case (rx_mode)
        RX_OPEN:  out_stall_i = 1'b0;
        RX_LIGHT: out_stall_i = ($urandom_range(0, 99) < 25);
        RX_HEAVY: out_stall_i = ($urandom_range(0, 99) < 75);
        default:  out_stall_i = ((cyc % 7) < 3);
      endcase
    end
  end

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) || cfg_we_i)
        quiet = 0;
      else
        quiet++;
    end
    $display("watchdog: no handshake for %0d cycles, %0d replies outstanding",
             WATCHDOG_LIMIT, pending);
    $display("== FAIL ==");
    $finish;
  end

  function automatic logic [BYTE_W-1:0] data_byte();
    case ($urandom_range(0, 9))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return START_BYTE;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Offers one item; called and returns at a falling edge.
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (max_gap == 0) ? 0 : $urandom_range(0, max_gap);
      if (gap > 0) begin
        in_valid_i = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    burst_left--;
    in_valid_i = 1'b1;
    rx_byte_i = b;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    @(negedge clk_i);
  endtask

  task automatic send_frame(input frame_fault_e fault, input logic [BYTE_W-1:0] cmd,
                            input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] len);
    logic [BYTE_W-1:0] frame[$];
    logic [BYTE_W-1:0] hsum;
    logic [BYTE_W-1:0] dsum;
    logic [BYTE_W-1:0] d;
    hsum = START_BYTE + cmd + id + len;
    if (fault == FAULT_HEAD) hsum = hsum + 8'($urandom_range(1, 255));
    frame.push_back(START_BYTE);
    frame.push_back(cmd);
    frame.push_back(id);
    frame.push_back(len);
    frame.push_back(hsum);
    // zero length ends at the header sum; over-long never gets past the length
    if (len != 0 && len <= MAX_DATA_DEF) begin
      dsum = '0;
      for (int i = 0; i < len; i++) begin
        d = data_byte();
        frame.push_back(d);
        dsum = dsum + d;
      end
      if (fault == FAULT_DATA) dsum = dsum + 8'($urandom_range(1, 255));
      frame.push_back(dsum);
    end
    foreach (frame[i]) send_byte(frame[i]);
    frame_bytes += frame.size();
  endtask

  task automatic write_motor_id(input logic [BYTE_W-1:0] id);
    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    cfg_we_i = 1'b1;
    cfg_wdata_i = id;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    cur_id = id;
  endtask

  // Mostly well-formed frames; noise bytes do not count towards the budget
  task automatic run_frames(input int budget);
    int start_bytes;
    int pick;
    logic [BYTE_W-1:0] cmd;
    logic [BYTE_W-1:0] len;
    start_bytes = frame_bytes;
    while (frame_bytes - start_bytes < budget) begin
      pick = $urandom_range(0, 99);
      cmd = 8'($urandom_range(0, 255));
      len = 8'($urandom_range(0, MAX_DATA_DEF));
      if (pick < 62)
        send_frame(FAULT_NONE, cmd, cur_id, len);
      else if (pick < 72)
        send_frame(FAULT_DATA, cmd, cur_id, 8'($urandom_range(1, MAX_DATA_DEF)));
      else if (pick < 79)
        send_frame(FAULT_HEAD, cmd, cur_id, len);
      else if (pick < 86)
        send_frame(FAULT_NONE, cmd, cur_id ^ 8'($urandom_range(1, 255)), len);
      else if (pick < 92)
        send_frame(FAULT_NONE, cmd, cur_id, 8'($urandom_range(MAX_DATA_DEF + 1, 255)));
      else
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
    end
  endtask

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    in_valid_i = 1'b0;
    rx_byte_i = '0;
    hold_req = 1'b0;
    rx_mode = RX_OPEN;
    max_gap = 0;
    burst_left = 0;
    frame_bytes = 0;
    cur_id = MOTOR_ID_RST;
    id_plan[4] = 8'($urandom_range(0, 255));
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed: stray byte, empty frame, each format error, bad data sum
    send_byte(8'hA5);
    send_frame(FAULT_NONE, 8'hFF, cur_id, 8'd0);
    send_frame(FAULT_NONE, 8'h00, cur_id + 8'd1, 8'd0);
    send_frame(FAULT_NONE, 8'h92, cur_id, 8'hFF);
    send_frame(FAULT_HEAD, 8'h30, cur_id, 8'd0);
    send_frame(FAULT_DATA, 8'hA1, cur_id, 8'd1);

    for (int p = 0; p < 6; p++) begin
      if (p > 0) write_motor_id(id_plan[p]);
      rx_mode = rx_mode_e'(p % 4);
      max_gap = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 3 : 12);
      if (p == 2) begin
        // receiver holds off while short frames keep coming: block backs up
        hold_req = 1'b1;
        repeat (24) send_frame(FAULT_NONE, 8'($urandom_range(0, 255)), cur_id, 8'd0);
      end
      run_frames(180);
    end

    in_valid_i = 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    $display("Run covered %0d frame bytes over 6 motor id settings (0x00, 0xFF, 0x3E, reset)",
             frame_bytes);
    $display("with all reply statuses; %0d replies compared, %0d mismatches",
             replies, mismatches);
    if (mismatches == 0 && pending == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
